### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the roll/pitch filter.
// Needs signals clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

### rtl/crpf_pkg.sv
// Package of the roll/pitch filter: constants, arctangent table, sequencer states.
// No dependencies.
`default_nettype none

package crpf_pkg;

  localparam int CordicIter = 16;
  localparam int SqrtIter   = 16;
  localparam int LoopMax    = (CordicIter > SqrtIter) ? CordicIter : SqrtIter;
  localparam int CntW       = $clog2(LoopMax);

  // shared multiplier operand and product widths
  localparam int MulAW = 36;
  localparam int MulBW = 22;
  localparam int MulPW = MulAW + MulBW;

  localparam logic signed [31:0] PiQ28      = 32'sd843314857;
  localparam logic signed [21:0] GyroScale  = 22'sd614083;
  // 6007897930 split as Hi * 2^16 + Lo
  localparam logic signed [21:0] CentiHi    = 22'sd91673;
  localparam logic signed [21:0] CentiLo    = 22'sd16202;

  // register addresses (index selects by paddr[2])
  localparam logic RegGyroWeight = 1'b0;
  localparam logic RegFullScale  = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ0, S_SQ1, S_SQ2, S_SQRT, S_CINIT, S_CORD,
    S_G1, S_G2, S_G3, S_G4, S_G5, S_B1, S_B2, S_B3,
    S_C1, S_C2, S_C3, S_DONE
  } st_e;

  // atan(2^-i) in Q4.28
  function automatic logic signed [31:0] atan_q28(input logic [4:0] idx);
    logic signed [31:0] r;
    begin
      unique case (idx)
        5'd0:  r = 32'sd210828714;
        5'd1:  r = 32'sd124459457;
        5'd2:  r = 32'sd65760959;
        5'd3:  r = 32'sd33381290;
        5'd4:  r = 32'sd16755422;
        5'd5:  r = 32'sd8385879;
        5'd6:  r = 32'sd4193963;
        5'd7:  r = 32'sd2097109;
        5'd8:  r = 32'sd1048571;
        5'd9:  r = 32'sd524287;
        5'd10: r = 32'sd262144;
        5'd11: r = 32'sd131072;
        5'd12: r = 32'sd65536;
        5'd13: r = 32'sd32768;
        5'd14: r = 32'sd16384;
        5'd15: r = 32'sd8192;
        5'd16: r = 32'sd4096;
        5'd17: r = 32'sd2048;
        5'd18: r = 32'sd1024;
        5'd19: r = 32'sd512;
        5'd20: r = 32'sd256;
        5'd21: r = 32'sd128;
        5'd22: r = 32'sd64;
        5'd23: r = 32'sd32;
        default: r = 32'sd0;
      endcase
      return r;
    end
  endfunction

endpackage

`default_nettype wire

### rtl/crpf_ifs.sv
// Valid/ready channel interfaces for the roll/pitch filter.
// No dependencies.
`default_nettype none

interface crpf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] rate_x;
  logic signed [15:0] rate_y;
  logic        [15:0] step_time_us;
  modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, step_time_us,
                  input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, step_time_us,
                output ready);
endinterface

interface crpf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_rad;
  logic signed [15:0] pitch_rad;
  logic signed [15:0] roll_centideg;
  logic signed [15:0] pitch_centideg;
  modport source (output valid, roll_rad, pitch_rad, roll_centideg, pitch_centideg,
                  input ready);
  modport sink (input valid, roll_rad, pitch_rad, roll_centideg, pitch_centideg,
                output ready);
endinterface

`default_nettype wire

### rtl/crpf_mul.sv
// Shared signed multiplier with a registered product.
// Depends on crpf_pkg.
`default_nettype none

module crpf_mul (
  input  wire logic                          clk_i,
  input  wire logic signed [crpf_pkg::MulAW-1:0] a_i,
  input  wire logic signed [crpf_pkg::MulBW-1:0] b_i,
  output logic signed [crpf_pkg::MulPW-1:0]  p_o
);
  import crpf_pkg::*;

  logic signed [MulPW-1:0] p_q;

  // product register, one product per cycle
  always_ff @(posedge clk_i) begin
    p_q <= MulPW'(a_i) * MulPW'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

### rtl/complementary_roll_pitch_filter.sv
// Complementary roll/pitch filter: sequencer, sqrt, CORDIC and blend around one multiplier.
// Depends on crpf_pkg, crpf_ifs, crpf_mul and assert_macros.svh.
//
//   channel  | dir | handshake          | content
//   ---------+-----+--------------------+-------------------------------------
//   in_ch    | in  | valid/ready        | accel x/y/z, gyro rate x/y, step time
//   out_ch   | out | valid/ready        | roll/pitch in Q3.13 rad and centideg
//   apb      | in  | psel/penable/pready| gyro_weight @0, gyro_full_scale_dps @4
//
// Per axis the sequencer runs the square/sum steps, the iterative root, a CORDIC init,
// CordicIter CORDIC steps and the multiplier steps; after both axes it loads the output
// register once it is free, returns to idle and accepts there. The shared multiplier
// and the iterative root and CORDIC loops set the time an item takes.
// in_ch.ready is high only while the sequencer is idle.
// A result waits in the output register; a new item is accepted meanwhile.
// Reset clears the estimates to zero and the configuration registers to their defaults.
`default_nettype none
`include "assert_macros.svh"

module complementary_roll_pitch_filter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  crpf_in_if.sink          in_ch,
  crpf_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import crpf_pkg::*;

  st_e state_q, state_d;
  logic            axis_q;
  logic [CntW-1:0] cnt_q;

  logic [15:0] w_q;
  logic [10:0] fs_q;

  logic signed [15:0] ax_q, ay_q, az_q, rx_q, ry_q;
  logic        [15:0] dt_q;

  logic        [31:0] sq_q, rem_q, root_q;
  logic signed [34:0] x_q, y_q;
  logic signed [31:0] z_q, acc_q, inc_q;
  logic               zero_q;
  logic        [21:0] lo_q;
  logic signed [MulPW-1:0] hp_q, bsum_q;
  logic signed [31:0] roll_est_q, pitch_est_q;
  logic signed [15:0] rad_q [2];
  logic signed [15:0] cd_q [2];
  logic               out_valid_q;
  logic signed [15:0] o_roll_rad_q, o_pitch_rad_q, o_roll_cd_q, o_pitch_cd_q;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulPW-1:0] prod;

  crpf_mul u_mul (.clk_i(clk_i), .a_i(mul_a), .b_i(mul_b), .p_o(prod));

  // configuration port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == RegFullScale) ? {21'd0, fs_q} : {16'd0, w_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q  <= 16'd64225;
      fs_q <= 11'd2000;
    end else if (cfg_wr) begin
      if (paddr[2] == RegGyroWeight) w_q <= pwdata[15:0];
      else fs_q <= pwdata[10:0];
    end
  end

  // per-axis operand selection
  logic signed [15:0] sq_src, rate_sel;
  logic signed [16:0] y_src;
  logic signed [31:0] est_sel;
  assign sq_src   = axis_q ? ay_q : ax_q;
  assign rate_sel = axis_q ? ry_q : rx_q;
  assign y_src    = axis_q ? -17'(ax_q) : 17'(ay_q);
  assign est_sel  = axis_q ? pitch_est_q : roll_est_q;

  logic in_acc, out_load, last_sqrt, last_cord;
  assign in_acc    = in_ch.valid && (state_q == S_IDLE);
  assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_ch.ready);
  assign last_sqrt = (cnt_q == CntW'(SqrtIter - 1));
  assign last_cord = (cnt_q == CntW'(CordicIter - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_ch.valid) state_d = S_SQ0;
      S_SQ0:   state_d = S_SQ1;
      S_SQ1:   state_d = S_SQ2;
      S_SQ2:   state_d = S_SQRT;
      S_SQRT:  if (last_sqrt) state_d = S_CINIT;
      S_CINIT: state_d = S_CORD;
      S_CORD:  if (last_cord) state_d = S_G1;
      S_G1:    state_d = S_G2;
      S_G2:    state_d = S_G3;
      S_G3:    state_d = S_G4;
      S_G4:    state_d = S_G5;
      S_G5:    state_d = S_B1;
      S_B1:    state_d = S_B2;
      S_B2:    state_d = S_B3;
      S_B3:    state_d = S_C1;
      S_C1:    state_d = S_C2;
      S_C2:    state_d = S_C3;
      S_C3:    state_d = axis_q ? S_DONE : S_SQ0;
      S_DONE:  if (!out_valid_q || out_ch.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_SQ0: begin
        mul_a = MulAW'(sq_src);
        mul_b = MulBW'(sq_src);
      end
      S_SQ1: begin
        mul_a = MulAW'(az_q);
        mul_b = MulBW'(az_q);
      end
      S_G1: begin
        mul_a = MulAW'(rate_sel);
        mul_b = MulBW'($signed({1'b0, fs_q}));
      end
      S_G2: begin
        mul_a = MulAW'($signed(prod[26:0]));
        mul_b = MulBW'($signed({1'b0, dt_q}));
      end
      S_G3: begin
        mul_a = MulAW'($signed(prod[42:22]));
        mul_b = GyroScale;
      end
      S_G4: begin
        mul_a = MulAW'($signed({1'b0, lo_q}));
        mul_b = GyroScale;
      end
      S_B1: begin
        mul_a = MulAW'(33'(est_sel) + 33'(inc_q));
        mul_b = MulBW'($signed({1'b0, w_q}));
      end
      S_B2: begin
        mul_a = MulAW'(acc_q);
        mul_b = MulBW'($signed({1'b0, 17'd65536 - {1'b0, w_q}}));
      end
      S_C1: begin
        mul_a = MulAW'(est_sel);
        mul_b = CentiHi;
      end
      S_C2: begin
        mul_a = MulAW'(est_sel);
        mul_b = CentiLo;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // square root step
  logic [31:0] sq_bit, sq_trial;
  logic        sq_ge;
  assign sq_bit   = 32'h4000_0000 >> {cnt_q[3:0], 1'b0};
  assign sq_trial = root_q + sq_bit;
  assign sq_ge    = rem_q >= sq_trial;

  // CORDIC step
  logic signed [34:0] dx, dy;
  logic signed [31:0] at, z_d;
  assign dx  = y_q >>> cnt_q;
  assign dy  = x_q >>> cnt_q;
  assign at  = atan_q28(5'(cnt_q));
  assign z_d = y_q[34] ? z_q - at : z_q + at;

  // gyro increment, blend and output scaling
  logic signed [63:0] inc_t, bl_t, bl_v, cd_t;
  logic signed [31:0] bl_c;
  logic signed [32:0] rad_t;
  assign inc_t = (64'(hp_q) <<< 22) + 64'(prod) + 64'sd2147483648;
  assign bl_t  = 64'(bsum_q) + 64'(prod) + 64'sd32768;
  assign bl_v  = bl_t >>> 16;
  assign bl_c  = (bl_v > 64'(PiQ28)) ? PiQ28 :
                 (bl_v < -64'(PiQ28)) ? -PiQ28 : 32'(bl_v);
  assign cd_t  = ((64'(hp_q) <<< 16) + 64'(prod) + 64'sd140737488355328) >>> 48;
  assign rad_t = (33'(est_sel) + 33'sd16384) >>> 15;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= 1'b0;
      cnt_q       <= '0;
      roll_est_q  <= '0;
      pitch_est_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) axis_q <= 1'b0;
      else if (state_q == S_C3) axis_q <= 1'b1;
      if ((state_q == S_SQRT && !last_sqrt) || (state_q == S_CORD && !last_cord))
        cnt_q <= cnt_q + CntW'(1);
      else
        cnt_q <= '0;
      if (state_q == S_B3) begin
        if (axis_q) pitch_est_q <= bl_c;
        else roll_est_q <= bl_c;
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ch.ready) out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ax_q <= in_ch.accel_x;
      ay_q <= in_ch.accel_y;
      az_q <= in_ch.accel_z;
      rx_q <= in_ch.rate_x;
      ry_q <= in_ch.rate_y;
      dt_q <= in_ch.step_time_us;
    end
    case (state_q)
      S_SQ1: sq_q <= prod[31:0];
      S_SQ2: begin
        rem_q  <= sq_q + prod[31:0];
        root_q <= '0;
      end
      S_SQRT: begin
        if (sq_ge) begin
          rem_q  <= rem_q - sq_trial;
          root_q <= (root_q >> 1) + sq_bit;
        end else begin
          root_q <= root_q >> 1;
        end
      end
      S_CINIT: begin
        x_q    <= $signed({3'b000, root_q[17:0], 14'd0});
        y_q    <= 35'(y_src) <<< 14;
        z_q    <= '0;
        zero_q <= (root_q == 32'd0) && (y_src == 17'sd0);
      end
      S_CORD: begin
        if (y_q[34]) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
        end
        z_q <= z_d;
        if (last_cord) acc_q <= zero_q ? 32'sd0 : z_d;
      end
      S_G3: lo_q <= prod[21:0];
      S_G4: hp_q <= prod;
      S_G5: inc_q <= 32'(inc_t >>> 32);
      S_B2: bsum_q <= prod;
      S_C2: hp_q <= prod;
      S_C3: begin
        rad_q[axis_q] <= 16'(rad_t);
        cd_q[axis_q]  <= 16'(cd_t);
      end
      default: ;
    endcase
    if (out_load) begin
      o_roll_rad_q  <= rad_q[0];
      o_pitch_rad_q <= rad_q[1];
      o_roll_cd_q   <= cd_q[0];
      o_pitch_cd_q  <= cd_q[1];
    end
  end

  assign in_ch.ready           = (state_q == S_IDLE);
  assign out_ch.valid          = out_valid_q;
  assign out_ch.roll_rad       = o_roll_rad_q;
  assign out_ch.pitch_rad      = o_pitch_rad_q;
  assign out_ch.roll_centideg  = o_roll_cd_q;
  assign out_ch.pitch_centideg = o_pitch_cd_q;

  // checks
  `ASSERT_IMP(a_roll_range, 1'b1, (roll_est_q <= PiQ28) && (roll_est_q >= -PiQ28))
  `ASSERT_IMP(a_pitch_range, 1'b1, (pitch_est_q <= PiQ28) && (pitch_est_q >= -PiQ28))
  `ASSERT_NXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
  `ASSERT_IMP(a_cord_count, state_q == S_CORD, cnt_q <= CntW'(CordicIter - 1))

endmodule

`default_nettype wire
